>>> hw/rtl/lcw_pkg.sv
// ----------------------------------------------------------------------------
// lcw_pkg: shared types and constants of the lock-click window sequencer
// Holds the classified frame item that travels from the front end to the back
// end, the configuration bundle, and the timing and field constants.
// ----------------------------------------------------------------------------
package lcw_pkg;

  // Configuration register indexes.
  localparam logic REG_CLOSE_MODE = 1'b0;
  localparam logic REG_OPEN_MODE  = 1'b1;

  // Mode register values; any other nonzero value asks for repeated clicks.
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_SINGLE = 2'd1;

  // Frame field codes.
  localparam logic [3:0] FRAME_LEN_ACTIVE = 4'd8;
  localparam logic [3:0] IGN_RUN          = 4'h8;
  localparam logic [3:0] FN_LOCK          = 4'h1;
  localparam logic [3:0] FN_UNLOCK_A      = 4'h3;
  localparam logic [3:0] FN_UNLOCK_B      = 4'h4;
  localparam logic [7:0] REQ_MASK         = 8'h0E;
  localparam logic [7:0] REQ_PASSIVE      = 8'h04;
  localparam logic [7:0] FOB_MASK         = 8'h1E;
  localparam logic [7:0] FOB_CLOSE_ALL    = 8'h01;
  localparam logic [7:0] REQ_OPEN_CODE    = 8'hB0;

  // Timing thresholds in milliseconds.
  localparam logic [31:0] LOCK_WINDOW_MS = 32'd3000;
  localparam logic [31:0] SEND_DELAY_MS  = 32'd3500;
  localparam logic [31:0] MOVE_DONE_MS   = 32'd8000;
  localparam logic [31:0] AJAR_START_MS  = 32'd8500;
  localparam logic [31:0] AJAR_DONE_MS   = 32'd8900;

  localparam logic [7:0] CLICKS_MAX = 8'hFF;

  typedef struct packed {
    logic [1:0] close_mode;
    logic [1:0] open_mode;
  } cfg_t;

  typedef struct packed {
    logic        act;        // frame length is 8
    logic        eng;        // ignition not in RUN (only when act)
    logic        is_lock;
    logic        is_unlock;
    logic        passive;    // passive-entry requestor
    logic [7:0]  fob;
    logic [7:0]  req;
    logic [31:0] now;
  } item_t;

endpackage

>>> hw/rtl/lcw_front.sv
// ----------------------------------------------------------------------------
// lcw_front: frame classifier
// Decodes length, ignition state and the function and requestor fields of an
// incoming frame into a compact item for the back end.
// ----------------------------------------------------------------------------
module lcw_front (
  input  logic [3:0]      frame_length,
  input  logic [7:0]      ignition_byte,
  input  logic [7:0]      fob_byte,
  input  logic [7:0]      request_byte,
  input  logic [31:0]     now_ms,
  output lcw_pkg::item_t  item
);

  logic [3:0] fn;

  assign fn = request_byte[7:4];

  always_comb begin
    item.act       = (frame_length == lcw_pkg::FRAME_LEN_ACTIVE);
    item.eng       = item.act && (ignition_byte[3:0] != lcw_pkg::IGN_RUN);
    item.is_lock   = (fn == lcw_pkg::FN_LOCK);
    item.is_unlock = (fn == lcw_pkg::FN_UNLOCK_A) || (fn == lcw_pkg::FN_UNLOCK_B);
    item.passive   = ((request_byte & lcw_pkg::REQ_MASK) == lcw_pkg::REQ_PASSIVE);
    item.fob       = fob_byte;
    item.req       = request_byte;
    item.now       = now_ms;
  end

endmodule

>>> hw/rtl/lcw_queue.sv
// ----------------------------------------------------------------------------
// lcw_queue: two-entry item queue
// Decouples the classifier from the sequencer so that each side can stall on
// its own; items flow one per cycle while neither side stalls.
// ----------------------------------------------------------------------------
module lcw_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lcw_pkg::item_t  push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output lcw_pkg::item_t  head_item
);

  lcw_pkg::item_t mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

>>> hw/rtl/lcw_back.sv
// ----------------------------------------------------------------------------
// lcw_back: click counting and window command sequencer
// Carries out one classified item per cycle, unless the output is stalled,
// against the click counters and phase state, and holds the rewritten frame in an output register.
// ----------------------------------------------------------------------------
module lcw_back (
  input  logic            clk,
  input  logic            rst,
  input  lcw_pkg::cfg_t   cfg,
  input  logic            item_valid,
  input  lcw_pkg::item_t  item,
  output logic            item_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            forward_frame,
  output logic [7:0]      new_fob_byte,
  output logic [7:0]      new_request_byte,
  output logic            engine_flag_clear
);

  typedef enum logic [1:0] {
    PHASE_IDLE    = 2'd0,
    PHASE_CLOSING = 2'd1,
    PHASE_AJAR    = 2'd2
  } phase_t;

  phase_t      close_phase, close_phase_next;
  logic [7:0]  lock_clicks, lock_clicks_next;
  logic [31:0] last_lock_time, last_lock_time_next;
  logic        open_pending, open_pending_next;
  logic [7:0]  unlock_clicks, unlock_clicks_next;
  logic [31:0] last_unlock_time, last_unlock_time_next;
  logic [7:0]  saved_fob, saved_fob_next;
  logic [7:0]  saved_requestor, saved_requestor_next;

  logic [31:0] dlock, dt_close, dunlock;
  logic        close_fwd, fwd;
  logic        open_lock, open_unlock;
  logic [7:0]  b1, b2;

  assign item_pop = item_valid && (!out_valid || !out_stall);
  assign dlock    = item.now - last_lock_time;
  assign dunlock  = item.now - last_unlock_time;
  assign dt_close = item.is_lock ? 32'd0 : dlock;

  always_comb begin
    close_phase_next      = close_phase;
    lock_clicks_next      = lock_clicks;
    last_lock_time_next   = last_lock_time;
    open_pending_next     = open_pending;
    unlock_clicks_next    = unlock_clicks;
    last_unlock_time_next = last_unlock_time;
    saved_fob_next        = saved_fob;
    saved_requestor_next  = saved_requestor;
    b1        = item.fob;
    b2        = item.req;
    close_fwd = 1'b0;
    open_lock   = 1'b0;
    open_unlock = 1'b0;

    // Close side.
    if (item.act && cfg.close_mode != lcw_pkg::MODE_OFF) begin
      if (item.is_lock) begin
        if (dlock < lcw_pkg::LOCK_WINDOW_MS) begin
          lock_clicks_next = (lock_clicks == lcw_pkg::CLICKS_MAX) ?
                             lock_clicks : lock_clicks + 8'd1;
        end else begin
          close_phase_next = PHASE_IDLE;
          lock_clicks_next = (cfg.close_mode == lcw_pkg::MODE_SINGLE) ? 8'd1 : 8'd0;
        end
        if (lock_clicks_next != 8'd0) begin
          saved_fob_next       = item.fob & lcw_pkg::FOB_MASK;
          saved_requestor_next = item.req & lcw_pkg::REQ_MASK;
          close_phase_next     = PHASE_CLOSING;
        end
        last_lock_time_next = item.now;
      end else if (item.is_unlock) begin
        close_phase_next = PHASE_IDLE;
        lock_clicks_next = 8'd0;
      end

      if (close_phase_next == PHASE_CLOSING) begin
        if (dt_close > lcw_pkg::SEND_DELAY_MS) begin
          b1        = saved_fob_next | lcw_pkg::FOB_CLOSE_ALL;
          b2        = saved_requestor_next;
          close_fwd = 1'b1;
          if (dt_close > lcw_pkg::MOVE_DONE_MS) begin
            if (lock_clicks_next >= 8'd2) begin
              close_phase_next = PHASE_AJAR;
            end else begin
              close_phase_next = PHASE_IDLE;
              lock_clicks_next = 8'd0;
            end
          end
        end
      end else if (close_phase_next == PHASE_AJAR) begin
        if (dt_close > lcw_pkg::AJAR_START_MS) begin
          b1        = saved_fob_next;
          b2        = lcw_pkg::REQ_OPEN_CODE | saved_requestor_next;
          close_fwd = 1'b1;
        end
        if (dt_close > lcw_pkg::AJAR_DONE_MS) begin
          close_phase_next = PHASE_IDLE;
          lock_clicks_next = 8'd0;
        end
      end
    end

    // Open side. A close rewrite leaves a function code that is neither a
    // lock nor an unlock, so the open side then sees no click.
    fwd = close_fwd;
    if (item.act && cfg.open_mode != lcw_pkg::MODE_OFF) begin
      open_lock   = item.is_lock && !close_fwd;
      open_unlock = item.is_unlock && !close_fwd;
      if (open_lock) begin
        open_pending_next  = 1'b0;
        unlock_clicks_next = 8'd0;
      end else if (open_unlock) begin
        if (!item.passive) begin
          if (dunlock < lcw_pkg::LOCK_WINDOW_MS) begin
            unlock_clicks_next = (unlock_clicks == lcw_pkg::CLICKS_MAX) ?
                                 unlock_clicks : unlock_clicks + 8'd1;
          end else begin
            open_pending_next  = 1'b0;
            unlock_clicks_next = (cfg.open_mode == lcw_pkg::MODE_SINGLE) ? 8'd1 : 8'd0;
          end
        end
        if (unlock_clicks_next != 8'd0) begin
          saved_fob_next       = item.fob & lcw_pkg::FOB_MASK;
          saved_requestor_next = item.req & lcw_pkg::REQ_MASK;
          open_pending_next    = 1'b1;
        end
        last_unlock_time_next = item.now;
      end

      // On an unlock click nothing is sent.
      if (open_pending_next && !open_unlock) begin
        if (dunlock > lcw_pkg::SEND_DELAY_MS) begin
          b1  = saved_fob_next;
          b2  = lcw_pkg::REQ_OPEN_CODE | saved_requestor_next;
          fwd = 1'b1;
          if (dunlock > lcw_pkg::MOVE_DONE_MS) begin
            open_pending_next  = 1'b0;
            unlock_clicks_next = 8'd0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      close_phase      <= PHASE_IDLE;
      lock_clicks      <= 8'd0;
      last_lock_time   <= 32'd0;
      open_pending     <= 1'b0;
      unlock_clicks    <= 8'd0;
      last_unlock_time <= 32'd0;
      saved_fob        <= 8'd0;
      saved_requestor  <= 8'd0;
      out_valid        <= 1'b0;
    end else begin
      if (item_pop) begin
        close_phase       <= close_phase_next;
        lock_clicks       <= lock_clicks_next;
        last_lock_time    <= last_lock_time_next;
        open_pending      <= open_pending_next;
        unlock_clicks     <= unlock_clicks_next;
        last_unlock_time  <= last_unlock_time_next;
        saved_fob         <= saved_fob_next;
        saved_requestor   <= saved_requestor_next;
        out_valid         <= 1'b1;
        forward_frame     <= fwd;
        new_fob_byte      <= b1;
        new_request_byte  <= b2;
        engine_flag_clear <= item.eng;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/lock_click_window_command_fsm_top.sv
// ----------------------------------------------------------------------------
// lock_click_window_command_fsm_top: lock-click window command sequencer
// Counts lock and unlock clicks on body-control frames and rewrites bytes 1
// and 2 to drive close, ajar and open window sequences.
// ----------------------------------------------------------------------------
// Usage: one frame (length, bytes 0 to 2, millisecond timestamp) enters per
// transaction on the input channel, taken at an edge where in_valid is high
// and in_stall is low. Every frame yields exactly one result transaction on
// the output channel, taken where out_valid is high and out_stall is low.
// The classifier writes each frame into a two-entry queue; the sequencer
// pops one item per cycle into the output register while the output is not
// stalled, so each result is registered first in the queue and then in the
// output register. The block sustains one frame per cycle while the receiver
// does not stall; the rate is set by the sequencer's state update.
// When the receiver stalls, the output register holds its result, the queue
// fills, and in_stall rises once both queue entries are occupied; no item
// is lost or repeated. Reset clears the click counters, timestamps, phase
// state, saved bytes, both mode registers and the queue. The mode registers
// are written through the configuration channel, which is always ready;
// write them only while no frame is in flight.
// ----------------------------------------------------------------------------
module lock_click_window_command_fsm_top (
  input  logic        clk,
  input  logic        rst,
  // Frame input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  frame_length,
  input  logic [7:0]  ignition_byte,
  input  logic [7:0]  fob_byte,
  input  logic [7:0]  request_byte,
  input  logic [31:0] now_ms,
  // Result output channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic        forward_frame,
  output logic [7:0]  new_fob_byte,
  output logic [7:0]  new_request_byte,
  output logic        engine_flag_clear,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_data
);

  lcw_pkg::cfg_t  cfg;
  lcw_pkg::item_t front_item;
  lcw_pkg::item_t head_item;
  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           head_valid;

  // Mode registers; writes are always accepted.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.close_mode <= 2'd0;
      cfg.open_mode  <= 2'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lcw_pkg::REG_CLOSE_MODE: cfg.close_mode <= cfg_data;
        lcw_pkg::REG_OPEN_MODE:  cfg.open_mode  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The front end stalls only when both queue entries are occupied.
  assign in_stall = q_full;
  assign q_push   = in_valid && !in_stall;

  lcw_front u_front (
    .frame_length  (frame_length),
    .ignition_byte (ignition_byte),
    .fob_byte      (fob_byte),
    .request_byte  (request_byte),
    .now_ms        (now_ms),
    .item          (front_item)
  );

  lcw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (front_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  lcw_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .item_valid        (head_valid),
    .item              (head_item),
    .item_pop          (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .forward_frame     (forward_frame),
    .new_fob_byte      (new_fob_byte),
    .new_request_byte  (new_request_byte),
    .engine_flag_clear (engine_flag_clear)
  );

endmodule
